// ----- src/sfrm_pkg.sv -----
// Shared widths, constants, types and index helpers for the frame rate meter.
// Depends on nothing; every other file of the block imports it.
package sfrm_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int STAMP_W    = 63;
    localparam int TICK_W     = 32;
    localparam int RATE_W     = 16;
    localparam int PROD_W     = CNT_W + TICK_W;
    localparam int QUO_W      = RATE_W + 1;
    localparam int DEN_W      = STAMP_W + RATE_W;
    localparam int STEP_W     = $clog2(QUO_W);

    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(10000000);
    localparam logic [RATE_W-1:0] RATE_MAX   = '1;

    // Requests to the timestamp ring: one write and one read.
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } ring_req_t;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    // Distance from one ring slot forward to another.
    function automatic logic [CNT_W-1:0] ring_dist(input logic [IDX_W-1:0] from,
                                                   input logic [IDX_W-1:0] to);
        logic [CNT_W-1:0] f;
        logic [CNT_W-1:0] t;
        f = CNT_W'(from);
        t = CNT_W'(to);
        return (t >= f) ? t - f : t + CNT_W'(RING_DEPTH) - f;
    endfunction

    // True when stamp a lies at least one window length after stamp b.
    function automatic logic reaches(input logic [STAMP_W-1:0] a,
                                     input logic [STAMP_W-1:0] b,
                                     input logic [TICK_W-1:0]  tick);
        return {1'b0, a} >= ({1'b0, b} + (STAMP_W + 1)'(tick));
    endfunction

endpackage

// ----- src/sfrm_ring.sv -----
// Timestamp ring: single-port-write, single-read memory with registered read data.
// Depends on sfrm_pkg. Slots never written read back as zero through a fill count.
module sfrm_ring (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sfrm_pkg::ring_req_t        req,
    input  logic [sfrm_pkg::STAMP_W-1:0] wr_data,
    output logic [sfrm_pkg::STAMP_W-1:0] rd_data
);
    import sfrm_pkg::*;

    logic [STAMP_W-1:0] mem [RING_DEPTH];
    logic [STAMP_W-1:0] rd_data_reg;
    logic               rd_ok_reg;
    logic               rd_ok_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;

    // Writes land on slots 1, 2, ... and wrap to slot 0 last.
    always_comb
    begin
        rd_ok_next = (fill_reg == CNT_W'(RING_DEPTH)) ||
                     ((req.rd_addr != '0) && (CNT_W'(req.rd_addr) <= fill_reg));
        fill_next  = fill_reg;
        if (req.wr_en && (fill_reg != CNT_W'(RING_DEPTH)))
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (req.rd_en)
            begin
                rd_ok_reg <= rd_ok_next;
            end
        end
    end

    assign rd_data = rd_ok_reg ? rd_data_reg : '0;

endmodule

// ----- src/sfrm_div.sv -----
// Restoring serial divider, one quotient bit per cycle, saturating at the rate maximum.
// Depends on sfrm_pkg.
module sfrm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sfrm_pkg::PROD_W-1:0]  num,
    input  logic [sfrm_pkg::STAMP_W-1:0] den,
    output logic                         done,
    output logic [sfrm_pkg::RATE_W-1:0]  quotient
);
    import sfrm_pkg::*;

    logic [PROD_W-1:0] rem_reg;
    logic [PROD_W-1:0] rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              ge;
    logic [DEN_W-1:0]  diff;

    // The top quotient bit only says the result overflows the output width.
    always_comb
    begin
        ge       = DEN_W'(rem_reg) >= den_reg;
        diff     = DEN_W'(rem_reg) - den_reg;
        rem_next = ge ? diff[PROD_W-1:0] : rem_reg;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= {den, RATE_W'(0)};
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            den_reg <= den_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[QUO_W-1] ? RATE_MAX : quo_reg[RATE_W-1:0];

endmodule

// ----- src/sliding_window_frame_rate_meter.sv -----
// Top level of the sliding window frame rate meter: sequencer, ring indices, output stage.
// Depends on sfrm_pkg, sfrm_ring and sfrm_div.
//
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+------------------------------------------
//  config   | cfg_wr_en               | cfg_wr_data (tick_rate, 32 bit)
//  input    | in_valid / in_ready     | timestamp (63 bit)
//  output   | out_valid / out_ready   | rate_valid, frames_per_second, zero_span
//
// From acceptance a beat runs through the load and start states, then at most the walk,
// the zero-span check and the divider, before its result waits in the final state; the walk
// reads up to RING_DEPTH-1 ring slots after the start slot, one per cycle through the single read port.
// in_ready is high only while the sequencer is idle. The output register holds one result,
// so a new beat is taken while it waits; the next result stalls in the final state.
// After reset the ring reads as all zeros through a fill count; no clearing pass is needed.
module sliding_window_frame_rate_meter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [sfrm_pkg::TICK_W-1:0]  cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sfrm_pkg::STAMP_W-1:0] timestamp,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         rate_valid,
    output logic [sfrm_pkg::RATE_W-1:0]  frames_per_second,
    output logic                         zero_span
);
    import sfrm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_START = 7'b0000100,
        S_WALK  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [TICK_W-1:0]  tick_reg;
    logic [IDX_W-1:0]   newest_reg, newest_next;
    logic [IDX_W-1:0]   oldest_reg, oldest_next;
    logic [IDX_W-1:0]   ws_reg, ws_next;
    logic [IDX_W-1:0]   nxt_reg, nxt_next;
    logic [STAMP_W-1:0] ts_reg, ts_next;
    logic [STAMP_W-1:0] start_reg, start_next;
    logic               res_valid_reg, res_valid_next;
    logic               res_zero_reg, res_zero_next;
    logic [RATE_W-1:0]  res_rate_reg, res_rate_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_rv_reg, out_rv_next;
    logic               out_zero_reg, out_zero_next;
    logic [RATE_W-1:0]  out_rate_reg, out_rate_next;

    ring_req_t          ring_req;
    logic [STAMP_W-1:0] rd_data;
    logic               div_start;
    logic               div_done;
    logic [RATE_W-1:0]  div_rate;
    logic [PROD_W-1:0]  product;
    logic [STAMP_W-1:0] span;
    logic               hit;
    logic               ring_full;
    logic [IDX_W-1:0]   step_idx;
    logic [IDX_W-1:0]   push_idx;
    logic               accept;

    sfrm_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ring_req),
        .wr_data (timestamp),
        .rd_data (rd_data)
    );

    sfrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (product),
        .den      (span),
        .done     (div_done),
        .quotient (div_rate)
    );

    assign accept   = in_valid && in_ready;
    assign push_idx = wrap_inc(newest_reg);

    // The one window compare, shared by the start check and every step of the walk.
    assign hit       = reaches(ts_reg, rd_data, tick_reg);
    assign ring_full = (wrap_inc(newest_reg) == oldest_reg);
    assign step_idx  = wrap_inc((state_reg == S_START) ? ws_reg : nxt_reg);

    // Frames in the window times the window length; the divider registers it at start.
    assign product = PROD_W'(ring_dist(ws_reg, newest_reg) + 1'b1) * PROD_W'(tick_reg);
    assign span    = ts_reg - start_reg;

    always_comb
    begin
        state_next     = state_reg;
        newest_next    = newest_reg;
        oldest_next    = oldest_reg;
        ws_next        = ws_reg;
        nxt_next       = nxt_reg;
        ts_next        = ts_reg;
        start_next     = start_reg;
        res_valid_next = res_valid_reg;
        res_zero_next  = res_zero_reg;
        res_rate_next  = res_rate_reg;
        out_rv_next    = out_rv_reg;
        out_zero_next  = out_zero_reg;
        out_rate_next  = out_rate_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ring_req       = '0;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Push the stamp; overwriting the oldest slot drags the window along.
                    ring_req.wr_en   = 1'b1;
                    ring_req.wr_addr = push_idx;
                    newest_next      = push_idx;
                    ts_next          = timestamp;
                    res_valid_next   = 1'b0;
                    res_zero_next    = 1'b0;
                    res_rate_next    = '0;
                    if (push_idx == oldest_reg)
                    begin
                        oldest_next = wrap_inc(oldest_reg);
                        if ((oldest_next == ws_reg) && (push_idx != ws_reg))
                        begin
                            ws_next = wrap_inc(ws_reg);
                        end
                    end
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                ring_req.rd_en   = 1'b1;
                ring_req.rd_addr = ws_reg;
                state_next       = S_START;
            end
            S_START, S_WALK:
            begin
                if (hit)
                begin
                    // This slot is still a full window old, so the window may start here.
                    if (state_reg == S_WALK)
                    begin
                        ws_next = nxt_reg;
                    end
                    start_next     = rd_data;
                    res_valid_next = 1'b1;
                    if (step_idx == newest_reg)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        ring_req.rd_en   = 1'b1;
                        ring_req.rd_addr = step_idx;
                        nxt_next         = step_idx;
                        state_next       = S_WALK;
                    end
                end
                else if (state_reg == S_WALK)
                begin
                    state_next = S_MUL;
                end
                else if (ring_full)
                begin
                    start_next     = rd_data;
                    res_valid_next = 1'b1;
                    state_next     = S_MUL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                // A stamp at or before the window start counts as a zero span.
                if (ts_reg <= start_reg)
                begin
                    res_zero_next = 1'b1;
                    res_rate_next = RATE_MAX;
                    state_next    = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_rate_next = div_rate;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_rv_next    = res_valid_reg;
                    out_zero_next  = res_zero_reg;
                    out_rate_next  = res_rate_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= TICK_RESET;
            newest_reg    <= '0;
            oldest_reg    <= '0;
            ws_reg        <= IDX_W'(1 % RING_DEPTH);
            nxt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            newest_reg    <= newest_next;
            oldest_reg    <= oldest_next;
            ws_reg        <= ws_next;
            nxt_reg       <= nxt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                tick_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ts_reg        <= ts_next;
        start_reg     <= start_next;
        res_valid_reg <= res_valid_next;
        res_zero_reg  <= res_zero_next;
        res_rate_reg  <= res_rate_next;
        out_rv_reg    <= out_rv_next;
        out_zero_reg  <= out_zero_next;
        out_rate_reg  <= out_rate_next;
    end

    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = out_valid_reg;
    assign rate_valid        = out_rv_reg;
    assign frames_per_second = out_rate_reg;
    assign zero_span         = out_zero_reg;

endmodule

// ----- src/sfrm_checker.sv -----
// Port-level checks for the frame rate meter, attached to the top level by bind.
// Depends on sfrm_pkg and sliding_window_frame_rate_meter.
module sfrm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         rate_valid,
    input logic [sfrm_pkg::RATE_W-1:0]  frames_per_second,
    input logic                         zero_span
);
    import sfrm_pkg::*;

    // A zero span always reports the saturated rate.
    a_zero_span_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_span |-> rate_valid && (frames_per_second == RATE_MAX))
        else $error("zero span beat without a saturated rate");

    // A beat with no rate carries zeros in the other fields.
    a_no_rate_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rate_valid |-> (frames_per_second == '0) && !zero_span)
        else $error("beat without a rate carries a nonzero payload");

    // The meter works on one timestamp at a time.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after a beat");

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frames_per_second)
            && $stable(rate_valid) && $stable(zero_span))
        else $error("output beat changed while stalled");

endmodule

bind sliding_window_frame_rate_meter sfrm_checker u_sfrm_checker (.*);
